// ===== rtl/ect_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types and constants of the edge chain tracer: transaction codes,
// trace directions, configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ect_pkg;

    // Default image size limits
    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    // Field widths
    localparam int unsigned GRAD_W     = 8;
    localparam int unsigned COORD_W    = 8;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // Request codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Trace directions (one bit per compass side: up, down, left, right)
    localparam logic [3:0] DIR_U  = 4'h8;
    localparam logic [3:0] DIR_D  = 4'h4;
    localparam logic [3:0] DIR_L  = 4'h2;
    localparam logic [3:0] DIR_R  = 4'h1;
    localparam logic [3:0] DIR_LU = 4'hA;
    localparam logic [3:0] DIR_LD = 4'h6;
    localparam logic [3:0] DIR_RU = 4'h9;
    localparam logic [3:0] DIR_RD = 4'h5;

    // One pixel word of the image memory
    typedef struct packed {
        logic              mark;
        logic              vert;
        logic              anchor;
        logic [GRAD_W-1:0] grad;
    } pix_word_t;

    // Job phase
    typedef enum logic [1:0] {
        PH_LOAD,
        PH_SCAN,
        PH_EMIT,
        PH_DONE
    } phase_t;

    // Sequencer state
    typedef enum logic [3:0] {
        ST_READY,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_HALF,
        ST_STEP,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_FETCH,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/ect_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ect_if
// Valid/ready channels of the edge chain tracer: the request channel
// (pixel loads and point reads) and the response channel (chain points).
// ----------------------------------------------------------------------------
interface ect_req_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [ect_pkg::GRAD_W-1:0]      gradient;
    logic                            anchor_flag;
    logic                            vertical_flag;

    modport source (output valid, func, gradient, anchor_flag, vertical_flag, input ready);
    modport sink   (input valid, func, gradient, anchor_flag, vertical_flag, output ready);
endinterface

interface ect_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ect_pkg::COORD_W-1:0]     point_x;
    logic [ect_pkg::COORD_W-1:0]     point_y;
    logic                            chain_end;
    logic                            all_done;

    modport source (output valid, point_x, point_y, chain_end, all_done, input ready);
    modport sink   (input valid, point_x, point_y, chain_end, all_done, output ready);
endinterface

// ===== rtl/edge_chain_tracer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_chain_tracer
// Edge chain linking over a loaded gradient image.
//
// Usage: req carries one transaction per pixel (func = load) in raster
// order until width x height pixels are in; then func = read transactions
// each return one chain point on rsp. Loads return nothing; reads before the
// image is complete are dropped. After the last chain, every read returns
// all_done with zero coordinates. cfg_we writes img_width / img_height
// (saturated to 3..MAX) and restarts the job from loading.
// Timing: loads are taken back to back, one per cycle, unless the output
// register is full and stalled. A read inside a chain is answered from the
// registered buffer read via EMIT; the next read is taken only after it. A read
// that starts a new chain scans via SCAN and SCAN_CHK per pixel and SCAN per
// row wrap, then traces via STEP, RD_A, RD_B, RD_C per point and HALF per half,
// bounded by the single pixel read port (three neighbor reads, mark update).
// Reset: empty job, loading phase, registers at 256 x 256. Edge marks are
// cleared as pixels are loaded, so no clearing pass runs.
// Stall: one output register holds the response; req is held off while it
// is full and not being taken.
// ----------------------------------------------------------------------------
module edge_chain_tracer #(
    parameter int unsigned MAX_WIDTH  = ect_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = ect_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ect_req_if.sink                          req,
    ect_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [ect_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [ect_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int unsigned XW        = $clog2(MAX_WIDTH);
    localparam int unsigned YW        = $clog2(MAX_HEIGHT);
    localparam int unsigned WB        = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HB        = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned PAW       = XW + YW;
    localparam int unsigned PIX_DEPTH = 2 ** PAW;
    localparam int unsigned BUF_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned BAW       = $clog2(BUF_DEPTH);
    localparam int unsigned BCW       = $clog2(BUF_DEPTH + 1);
    localparam int unsigned CDW       = ect_pkg::CFG_DATA_W;
    localparam int unsigned OW        = ect_pkg::COORD_W;

    // Memories
    ect_pkg::pix_word_t pix_mem [PIX_DEPTH];
    logic [PAW-1:0]     buf_mem [BUF_DEPTH];

    logic               pix_we;
    logic [PAW-1:0]     pix_waddr;
    ect_pkg::pix_word_t pix_wdata;
    logic [PAW-1:0]     pix_raddr;
    ect_pkg::pix_word_t pix_rd_reg;

    logic               buf_we;
    logic [BAW-1:0]     buf_waddr;
    logic [PAW-1:0]     buf_wdata;
    logic [BAW-1:0]     buf_raddr;
    logic [PAW-1:0]     buf_rd_reg;

    // Control and datapath registers
    ect_pkg::state_t    state_reg, state_next;
    ect_pkg::phase_t    phase_reg, phase_next;
    logic [CDW-1:0]     cfg_w_reg, cfg_w_next;
    logic [CDW-1:0]     cfg_h_reg, cfg_h_next;
    logic [XW-1:0]      load_x_reg, load_x_next;
    logic [YW-1:0]      load_y_reg, load_y_next;
    logic [XW-1:0]      scan_x_reg, scan_x_next;
    logic [YW-1:0]      scan_y_reg, scan_y_next;
    logic [XW-1:0]      anc_x_reg, anc_x_next;
    logic [YW-1:0]      anc_y_reg, anc_y_next;
    ect_pkg::pix_word_t anc_word_reg, anc_word_next;
    logic [XW-1:0]      cur_x_reg, cur_x_next;
    logic [YW-1:0]      cur_y_reg, cur_y_next;
    logic [3:0]         dir_reg, dir_next;
    ect_pkg::pix_word_t cur_word_reg, cur_word_next;
    ect_pkg::pix_word_t word_a_reg, word_a_next;
    ect_pkg::pix_word_t word_b_reg, word_b_next;
    logic               second_reg, second_next;
    logic [BCW-1:0]     count_reg, count_next;
    logic [BCW-1:0]     half_reg, half_next;
    logic [BCW-1:0]     rd_idx_reg, rd_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [OW-1:0]      out_x_reg, out_x_next;
    logic [OW-1:0]      out_y_reg, out_y_next;
    logic               out_end_reg, out_end_next;
    logic               out_done_reg, out_done_next;

    // Effective image size
    logic [WB-1:0]      eff_w;
    logic [HB-1:0]      eff_h;

    // Neighbor geometry of the current trace point
    logic               nb_ok;
    logic [XW-1:0]      ax, bx, cx;
    logic [YW-1:0]      ay, by, cy;
    logic [3:0]         bdir, cdir, sdir;

    logic               req_fire;
    logic [BCW-1:0]     rd_idx_inc;

    // Saturate the size registers
    always_comb
    begin
        if (cfg_w_reg < CDW'(3))
            eff_w = WB'(3);
        else if (32'(cfg_w_reg) > MAX_WIDTH)
            eff_w = WB'(MAX_WIDTH);
        else
            eff_w = WB'(cfg_w_reg);
        if (cfg_h_reg < CDW'(3))
            eff_h = HB'(3);
        else if (32'(cfg_h_reg) > MAX_HEIGHT)
            eff_h = HB'(MAX_HEIGHT);
        else
            eff_h = HB'(cfg_h_reg);
    end

    // Find the three pixels ahead of the current point
    always_comb
    begin
        nb_ok = 1'b1;
        ax    = cur_x_reg;
        ay    = cur_y_reg;
        bx    = cur_x_reg;
        by    = cur_y_reg;
        cx    = cur_x_reg;
        cy    = cur_y_reg;
        bdir  = dir_reg;
        cdir  = dir_reg;
        sdir  = dir_reg;
        if (!cur_word_reg.vert)
        begin
            if ((dir_reg & ect_pkg::DIR_L) != 4'h0)
            begin
                ax   = cur_x_reg - XW'(1);
                bdir = ect_pkg::DIR_LU;
                cdir = ect_pkg::DIR_LD;
                sdir = ect_pkg::DIR_L;
            end
            else if ((dir_reg & ect_pkg::DIR_R) != 4'h0)
            begin
                ax   = cur_x_reg + XW'(1);
                bdir = ect_pkg::DIR_RU;
                cdir = ect_pkg::DIR_RD;
                sdir = ect_pkg::DIR_R;
            end
            else
            begin
                nb_ok = 1'b0;
            end
            ay = cur_y_reg;
            bx = ax;
            by = cur_y_reg - YW'(1);
            cx = ax;
            cy = cur_y_reg + YW'(1);
        end
        else
        begin
            if ((dir_reg & ect_pkg::DIR_U) != 4'h0)
            begin
                ay   = cur_y_reg - YW'(1);
                bdir = ect_pkg::DIR_LU;
                cdir = ect_pkg::DIR_RU;
                sdir = ect_pkg::DIR_U;
            end
            else if ((dir_reg & ect_pkg::DIR_D) != 4'h0)
            begin
                ay   = cur_y_reg + YW'(1);
                bdir = ect_pkg::DIR_LD;
                cdir = ect_pkg::DIR_RD;
                sdir = ect_pkg::DIR_D;
            end
            else
            begin
                nb_ok = 1'b0;
            end
            ax = cur_x_reg;
            bx = cur_x_reg - XW'(1);
            by = ay;
            cx = cur_x_reg + XW'(1);
            cy = ay;
        end
    end

    assign req.ready  = (state_reg == ect_pkg::ST_READY) && (!out_valid_reg || rsp.ready);
    assign req_fire   = req.valid && req.ready;
    assign rd_idx_inc = rd_idx_reg + BCW'(1);

    // Buffer read order: first half backward, then second half forward
    assign buf_raddr = (rd_idx_reg < half_reg) ? BAW'(half_reg - BCW'(1) - rd_idx_reg)
                                               : BAW'(rd_idx_reg);

    // Sequencer: next state, memory accesses and response
    always_comb
    begin
        logic              push;
        logic [XW-1:0]     push_x;
        logic [YW-1:0]     push_y;
        logic              end_half;
        logic              stop;
        logic [1:0]        cnt;
        ect_pkg::pix_word_t wc;
        logic              vdir;
        logic              hdir;

        state_next     = state_reg;
        phase_next     = phase_reg;
        cfg_w_next     = cfg_w_reg;
        cfg_h_next     = cfg_h_reg;
        load_x_next    = load_x_reg;
        load_y_next    = load_y_reg;
        scan_x_next    = scan_x_reg;
        scan_y_next    = scan_y_reg;
        anc_x_next     = anc_x_reg;
        anc_y_next     = anc_y_reg;
        anc_word_next  = anc_word_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dir_next       = dir_reg;
        cur_word_next  = cur_word_reg;
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        half_next      = half_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_end_next   = out_end_reg;
        out_done_next  = out_done_reg;

        pix_we    = 1'b0;
        pix_waddr = {cur_y_reg, cur_x_reg};
        pix_wdata = cur_word_reg;
        pix_raddr = {ay, ax};
        buf_we    = 1'b0;
        buf_waddr = BAW'(count_reg);
        buf_wdata = {cur_y_reg, cur_x_reg};

        push     = 1'b0;
        push_x   = cur_x_reg;
        push_y   = cur_y_reg;
        end_half = 1'b0;
        stop     = 1'b0;
        cnt      = 2'd0;
        wc       = pix_rd_reg;
        vdir     = (dir_reg == ect_pkg::DIR_U) || (dir_reg == ect_pkg::DIR_D);
        hdir     = (dir_reg == ect_pkg::DIR_L) || (dir_reg == ect_pkg::DIR_R);

        unique case (state_reg)
            ect_pkg::ST_READY:
            begin
                if (req_fire)
                begin
                    if (req.func == ect_pkg::FUNC_LOAD)
                    begin
                        // Store the pixel and clear its mark
                        if (phase_reg == ect_pkg::PH_LOAD)
                        begin
                            pix_we           = 1'b1;
                            pix_waddr        = {load_y_reg, load_x_reg};
                            pix_wdata.mark   = 1'b0;
                            pix_wdata.vert   = req.vertical_flag;
                            pix_wdata.anchor = req.anchor_flag;
                            pix_wdata.grad   = req.gradient;
                            if (WB'(load_x_reg) == eff_w - WB'(1))
                            begin
                                load_x_next = '0;
                                load_y_next = load_y_reg + YW'(1);
                                if (HB'(load_y_reg) == eff_h - HB'(1))
                                begin
                                    phase_next  = ect_pkg::PH_SCAN;
                                    scan_x_next = XW'(1);
                                    scan_y_next = YW'(1);
                                end
                            end
                            else
                            begin
                                load_x_next = load_x_reg + XW'(1);
                            end
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            ect_pkg::PH_LOAD:
                            begin
                                state_next = ect_pkg::ST_READY;
                            end
                            ect_pkg::PH_SCAN:
                            begin
                                state_next = ect_pkg::ST_SCAN;
                            end
                            ect_pkg::PH_EMIT:
                            begin
                                state_next = ect_pkg::ST_EMIT;
                            end
                            ect_pkg::PH_DONE:
                            begin
                                out_valid_next = 1'b1;
                                out_x_next     = '0;
                                out_y_next     = '0;
                                out_end_next   = 1'b0;
                                out_done_next  = 1'b1;
                            end
                            default:
                            begin
                                state_next = ect_pkg::ST_READY;
                            end
                        endcase
                    end
                end
            end

            ect_pkg::ST_SCAN:
            begin
                // Walk interior pixels in raster order
                pix_raddr = {scan_y_reg, scan_x_reg};
                if (HB'(scan_y_reg) > eff_h - HB'(2))
                begin
                    phase_next     = ect_pkg::PH_DONE;
                    state_next     = ect_pkg::ST_READY;
                    out_valid_next = 1'b1;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    out_end_next   = 1'b0;
                    out_done_next  = 1'b1;
                end
                else if (WB'(scan_x_reg) > eff_w - WB'(2))
                begin
                    scan_x_next = XW'(1);
                    scan_y_next = scan_y_reg + YW'(1);
                end
                else
                begin
                    state_next = ect_pkg::ST_SCAN_CHK;
                end
            end

            ect_pkg::ST_SCAN_CHK:
            begin
                scan_x_next = scan_x_reg + XW'(1);
                if (pix_rd_reg.anchor && !pix_rd_reg.mark)
                begin
                    // Start a chain with the anchor as its first point
                    anc_x_next    = scan_x_reg;
                    anc_y_next    = scan_y_reg;
                    anc_word_next = pix_rd_reg;
                    buf_we        = 1'b1;
                    buf_waddr     = '0;
                    buf_wdata     = {scan_y_reg, scan_x_reg};
                    count_next    = BCW'(1);
                    rd_idx_next   = '0;
                    second_next   = 1'b0;
                    state_next    = ect_pkg::ST_HALF;
                end
                else
                begin
                    state_next = ect_pkg::ST_SCAN;
                end
            end

            ect_pkg::ST_HALF:
            begin
                // Clear the anchor mark and aim the trace
                pix_we             = 1'b1;
                pix_waddr          = {anc_y_reg, anc_x_reg};
                pix_wdata          = anc_word_reg;
                pix_wdata.mark     = 1'b0;
                cur_word_next      = anc_word_reg;
                cur_word_next.mark = 1'b0;
                cur_x_next         = anc_x_reg;
                cur_y_next         = anc_y_reg;
                if (second_reg)
                    dir_next = anc_word_reg.vert ? ect_pkg::DIR_D : ect_pkg::DIR_R;
                else
                    dir_next = anc_word_reg.vert ? ect_pkg::DIR_U : ect_pkg::DIR_L;
                state_next = ect_pkg::ST_STEP;
            end

            ect_pkg::ST_STEP:
            begin
                pix_raddr = {ay, ax};
                if (!(cur_x_reg != '0 && WB'(cur_x_reg) < eff_w - WB'(1) &&
                      cur_y_reg != '0 && HB'(cur_y_reg) < eff_h - HB'(1)))
                    stop = 1'b1;
                else if (cur_word_reg.mark || cur_word_reg.grad == '0)
                    stop = 1'b1;
                else if ((!cur_word_reg.vert && vdir) || (cur_word_reg.vert && hdir))
                    stop = 1'b1;
                if (stop)
                begin
                    end_half = 1'b1;
                end
                else
                begin
                    // Mark the point, then fetch the pixels ahead
                    pix_we             = 1'b1;
                    pix_wdata          = cur_word_reg;
                    pix_wdata.mark     = 1'b1;
                    cur_word_next.mark = 1'b1;
                    if (nb_ok)
                        state_next = ect_pkg::ST_RD_A;
                    else
                        end_half = 1'b1;
                end
            end

            ect_pkg::ST_RD_A:
            begin
                pix_raddr   = {by, bx};
                word_a_next = pix_rd_reg;
                state_next  = ect_pkg::ST_RD_B;
            end

            ect_pkg::ST_RD_B:
            begin
                pix_raddr   = {cy, cx};
                word_b_next = pix_rd_reg;
                state_next  = ect_pkg::ST_RD_C;
            end

            ect_pkg::ST_RD_C:
            begin
                cnt = 2'(word_a_reg.mark) + 2'(word_b_reg.mark) + 2'(wc.mark);
                if (cnt >= 2'd2)
                begin
                    // Crowded: drop the mark and stop
                    pix_we         = 1'b1;
                    pix_wdata      = cur_word_reg;
                    pix_wdata.mark = 1'b0;
                    end_half       = 1'b1;
                end
                else if (cnt == 2'd1)
                begin
                    push     = 1'b1;
                    end_half = 1'b1;
                end
                else
                begin
                    // Advance to the strongest pixel ahead
                    if (word_b_reg.grad > word_a_reg.grad && word_b_reg.grad > wc.grad)
                    begin
                        cur_x_next    = bx;
                        cur_y_next    = by;
                        dir_next      = bdir;
                        cur_word_next = word_b_reg;
                    end
                    else if (wc.grad > word_a_reg.grad && wc.grad > word_b_reg.grad)
                    begin
                        cur_x_next    = cx;
                        cur_y_next    = cy;
                        dir_next      = cdir;
                        cur_word_next = wc;
                    end
                    else
                    begin
                        cur_x_next    = ax;
                        cur_y_next    = ay;
                        dir_next      = sdir;
                        cur_word_next = word_a_reg;
                    end
                    push       = 1'b1;
                    push_x     = cur_x_next;
                    push_y     = cur_y_next;
                    state_next = ect_pkg::ST_STEP;
                end
            end

            ect_pkg::ST_FETCH:
            begin
                state_next = ect_pkg::ST_EMIT;
            end

            ect_pkg::ST_EMIT:
            begin
                // Deliver one buffered point
                out_valid_next = 1'b1;
                out_x_next     = OW'(buf_rd_reg[XW-1:0]);
                out_y_next     = OW'(buf_rd_reg[PAW-1:XW]);
                out_end_next   = (rd_idx_inc >= count_reg);
                out_done_next  = 1'b0;
                rd_idx_next    = rd_idx_inc;
                if (rd_idx_inc >= count_reg)
                    phase_next = ect_pkg::PH_SCAN;
                state_next = ect_pkg::ST_READY;
            end

            default:
            begin
                state_next = ect_pkg::ST_READY;
            end
        endcase

        // Append a point to the chain buffer
        if (push && (32'(count_reg) < BUF_DEPTH))
        begin
            buf_we     = 1'b1;
            buf_waddr  = BAW'(count_reg);
            buf_wdata  = {push_y, push_x};
            count_next = count_reg + BCW'(1);
        end

        // Finish a half: turn around, or hand the chain to the reader
        if (end_half)
        begin
            if (!second_reg)
            begin
                half_next   = count_next;
                second_next = 1'b1;
                state_next  = ect_pkg::ST_HALF;
            end
            else
            begin
                phase_next  = ect_pkg::PH_EMIT;
                rd_idx_next = '0;
                state_next  = ect_pkg::ST_FETCH;
            end
        end

        // Register write restarts the job
        if (cfg_we)
        begin
            unique case (cfg_idx)
                ect_pkg::CFG_IDX_WIDTH:  cfg_w_next = cfg_wdata;
                ect_pkg::CFG_IDX_HEIGHT: cfg_h_next = cfg_wdata;
                default:                 cfg_w_next = cfg_w_reg;
            endcase
            phase_next  = ect_pkg::PH_LOAD;
            state_next  = ect_pkg::ST_READY;
            load_x_next = '0;
            load_y_next = '0;
            scan_x_next = XW'(1);
            scan_y_next = YW'(1);
            count_next  = '0;
            half_next   = '0;
            rd_idx_next = '0;
        end
    end

    // Pixel memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= pix_wdata;
        pix_rd_reg <= pix_mem[pix_raddr];
    end

    // Chain buffer memory
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_waddr] <= buf_wdata;
        buf_rd_reg <= buf_mem[buf_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ect_pkg::ST_READY;
            phase_reg     <= ect_pkg::PH_LOAD;
            cfg_w_reg     <= CDW'(256);
            cfg_h_reg     <= CDW'(256);
            load_x_reg    <= '0;
            load_y_reg    <= '0;
            scan_x_reg    <= XW'(1);
            scan_y_reg    <= YW'(1);
            second_reg    <= 1'b0;
            count_reg     <= '0;
            half_reg      <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cfg_w_reg     <= cfg_w_next;
            cfg_h_reg     <= cfg_h_next;
            load_x_reg    <= load_x_next;
            load_y_reg    <= load_y_next;
            scan_x_reg    <= scan_x_next;
            scan_y_reg    <= scan_y_next;
            second_reg    <= second_next;
            count_reg     <= count_next;
            half_reg      <= half_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        anc_x_reg    <= anc_x_next;
        anc_y_reg    <= anc_y_next;
        anc_word_reg <= anc_word_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        dir_reg      <= dir_next;
        cur_word_reg <= cur_word_next;
        word_a_reg   <= word_a_next;
        word_b_reg   <= word_b_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_end_reg  <= out_end_next;
        out_done_reg <= out_done_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.point_x   = out_x_reg;
    assign rsp.point_y   = out_y_reg;
    assign rsp.chain_end = out_end_reg;
    assign rsp.all_done  = out_done_reg;

endmodule
